### hdl/beacon_period_classifier_assert.svh
// assertion macros for the beacon period classifier checker
`ifndef BEACON_PERIOD_CLASSIFIER_ASSERT_SVH
`define BEACON_PERIOD_CLASSIFIER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define BPC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bpc assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define BPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bpc assertion failed");

`endif

### hdl/bpc_pkg.sv
// shared types and constants of the beacon period classifier
package bpc_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_DIV,
    ST_CLASS,
    ST_HIT,
    ST_LOSS_F,
    ST_LOSS_R
  } bpc_state_t;

  localparam logic [1:0] REQ_FRONT = 2'd0;
  localparam logic [1:0] REQ_REAR  = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  localparam logic [2:0] REG_TICKS_PER_MS = 3'd0;
  localparam logic [2:0] REG_PERIOD_ONE   = 3'd1;
  localparam logic [2:0] REG_PERIOD_TWO   = 3'd2;
  localparam logic [2:0] REG_PERIOD_THREE = 3'd3;
  localparam logic [2:0] REG_PERIOD_FOUR  = 3'd4;
  localparam logic [2:0] REG_NO_BEACON    = 3'd5;

  localparam logic [15:0] RST_TICKS_PER_MS = 16'd1500;
  localparam logic [15:0] RST_PERIOD_ONE   = 16'd20;
  localparam logic [15:0] RST_PERIOD_TWO   = 16'd18;
  localparam logic [15:0] RST_PERIOD_THREE = 16'd16;
  localparam logic [15:0] RST_PERIOD_FOUR  = 16'd14;
  localparam logic [31:0] RST_NO_BEACON    = 32'd33000;

  localparam logic [15:0] PERIOD_SAT  = 16'hFFFF;
  localparam logic [2:0]  BEACON_LOST = 3'd0;
  localparam int          NUM_BEACONS = 4;
  localparam logic [4:0]  DIV_LAST    = 5'd31;

  typedef struct packed {
    logic capture;
    logic div_start;
    logic div_step;
    logic classify;
    logic loss_eval;
    logic push;
    logic push_chan;
    logic push_loss;
    logic push_last;
  } bpc_cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic       div_done;
    logic       hit;
    logic       lose_front;
    logic       lose_rear;
    logic       out_free;
  } bpc_status_t;

endpackage

### hdl/beacon_period_classifier.sv
// beacon period classifier: edge words take one restoring divider step per cycle,
// a new edge word or tick is taken only once the last word has been handled,
// one output register lets the next word in while a result waits,
// rst_n is synchronous: settings return to defaults, beacon state clears
module beacon_period_classifier (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // capture_time, mode_allows, zero pad
  input  logic [1:0]  in_tuser,   // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // beacon, zero pad
  output logic        out_tuser,  // channel
  output logic        out_tlast
);
  import bpc_pkg::*;

  bpc_cmd_t    cmd;
  bpc_status_t status;

  bpc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .cmd      (cmd),
    .status   (status)
  );

  bpc_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .status     (status)
  );

endmodule

### hdl/bpc_ctrl.sv
// sequencing state machine of the beacon period classifier
module bpc_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output bpc_pkg::bpc_cmd_t     cmd,
  input  bpc_pkg::bpc_status_t  status
);
  import bpc_pkg::*;

  bpc_state_t state_r;
  bpc_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (status.req) inside
          REQ_FRONT, REQ_REAR: begin
            cmd.div_start = 1'b1;
            state_nxt     = ST_DIV;
          end
          REQ_TICK: begin
            cmd.loss_eval = 1'b1;
            state_nxt     = ST_LOSS_F;
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          state_nxt = ST_CLASS;
        end
      end
      ST_CLASS: begin
        cmd.classify = 1'b1;
        state_nxt    = ST_HIT;
      end
      ST_HIT: begin
        if (!status.hit) begin
          state_nxt = ST_IDLE;
        end else if (status.out_free) begin
          cmd.push      = 1'b1;
          cmd.push_chan = status.req[0];
          cmd.push_last = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_LOSS_F: begin
        if (!status.lose_front) begin
          state_nxt = ST_LOSS_R;
        end else if (status.out_free) begin
          cmd.push      = 1'b1;
          cmd.push_loss = 1'b1;
          cmd.push_last = !status.lose_rear;
          state_nxt     = ST_LOSS_R;
        end
      end
      ST_LOSS_R: begin
        if (!status.lose_rear) begin
          state_nxt = ST_IDLE;
        end else if (status.out_free) begin
          cmd.push      = 1'b1;
          cmd.push_chan = 1'b1;
          cmd.push_loss = 1'b1;
          cmd.push_last = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### hdl/bpc_dpath.sv
// datapath: settings, channel state, serial divider, matcher and output register
module bpc_dpath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_addr,
  input  logic [31:0]           cfg_wdata,
  input  logic [39:0]           in_tdata,
  input  logic [1:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata,
  output logic                  out_tuser,
  output logic                  out_tlast,
  input  bpc_pkg::bpc_cmd_t     cmd,
  output bpc_pkg::bpc_status_t  status
);
  import bpc_pkg::*;

  logic [15:0] ticks_r;
  logic [15:0] period_r [NUM_BEACONS];
  logic [31:0] no_beacon_r;

  logic [1:0]  req_r;
  logic [31:0] time_r;
  logic        allow_r;

  logic [2:0]  seen_r [2];
  logic [31:0] last_time_r [2];
  logic [15:0] last_period_r [2];

  logic [15:0] rem_r;
  logic [31:0] dvd_r;
  logic [4:0]  cnt_r;
  logic [2:0]  hit_r;
  logic        lose_f_r;
  logic        lose_rr_r;

  logic        out_valid_r;
  logic        out_chan_r;
  logic [2:0]  out_beacon_r;
  logic        out_last_r;

  logic        ch;
  logic [16:0] rem_shift;
  logic        q_bit;
  logic [15:0] rem_nxt;
  logic [31:0] dvd_nxt;
  logic [15:0] period;
  logic [2:0]  match;
  logic [15:0] pm1;
  logic        lose_f_nxt;
  logic        lose_r_nxt;
  logic        out_free;

  assign ch = req_r[0];

  // one restoring step per cycle
  always_comb begin
    rem_shift = {rem_r, dvd_r[31]};
    q_bit     = (rem_shift >= {1'b0, ticks_r});
    rem_nxt   = q_bit ? 16'(rem_shift - {1'b0, ticks_r}) : rem_shift[15:0];
    dvd_nxt   = {dvd_r[30:0], q_bit};
  end

  always_comb begin
    period = ((ticks_r == '0) || (dvd_r[31:16] != '0)) ? PERIOD_SAT : dvd_r[15:0];
    match  = BEACON_LOST;
    pm1    = '0;
    for (int k = NUM_BEACONS - 1; k >= 0; k--) begin
      pm1 = period_r[k] - 16'd1;
      if ((seen_r[ch] != 3'(k + 1)) && ((period == period_r[k]) || (period == pm1))) begin
        match = 3'(k + 1);
      end
    end
  end

  assign lose_f_nxt = (seen_r[0] != BEACON_LOST) && ((time_r - last_time_r[0]) > no_beacon_r);
  assign lose_r_nxt = (seen_r[1] != BEACON_LOST) && ((time_r - last_time_r[1]) > no_beacon_r);

  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_r        <= RST_TICKS_PER_MS;
      period_r[0]    <= RST_PERIOD_ONE;
      period_r[1]    <= RST_PERIOD_TWO;
      period_r[2]    <= RST_PERIOD_THREE;
      period_r[3]    <= RST_PERIOD_FOUR;
      no_beacon_r    <= RST_NO_BEACON;
      seen_r[0]      <= BEACON_LOST;
      seen_r[1]      <= BEACON_LOST;
      last_time_r[0] <= '0;
      last_time_r[1] <= '0;
      last_period_r[0] <= '0;
      last_period_r[1] <= '0;
      req_r          <= '0;
      hit_r          <= BEACON_LOST;
      lose_f_r       <= 1'b0;
      lose_rr_r      <= 1'b0;
      cnt_r          <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_TICKS_PER_MS: ticks_r     <= cfg_wdata[15:0];
          REG_PERIOD_ONE:   period_r[0] <= cfg_wdata[15:0];
          REG_PERIOD_TWO:   period_r[1] <= cfg_wdata[15:0];
          REG_PERIOD_THREE: period_r[2] <= cfg_wdata[15:0];
          REG_PERIOD_FOUR:  period_r[3] <= cfg_wdata[15:0];
          REG_NO_BEACON:    no_beacon_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.capture) begin
        req_r <= in_tuser;
      end
      if (cmd.div_start) begin
        cnt_r           <= '0;
        hit_r           <= BEACON_LOST;
        last_time_r[ch] <= time_r;
      end
      if (cmd.div_step) begin
        cnt_r <= cnt_r + 5'd1;
      end
      if (cmd.classify && allow_r && (period != last_period_r[ch])) begin
        last_period_r[ch] <= period;
        hit_r             <= match;
        if (match != BEACON_LOST) begin
          seen_r[ch] <= match;
        end
      end
      if (cmd.loss_eval) begin
        lose_f_r  <= lose_f_nxt;
        lose_rr_r <= lose_r_nxt;
        if (lose_f_nxt) begin
          seen_r[0] <= BEACON_LOST;
        end
        if (lose_r_nxt) begin
          seen_r[1] <= BEACON_LOST;
        end
      end
      if (cmd.push) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      time_r  <= in_tdata[31:0];
      allow_r <= in_tdata[32];
    end
    if (cmd.div_start) begin
      rem_r <= '0;
      dvd_r <= time_r - last_time_r[ch];
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      dvd_r <= dvd_nxt;
    end
    if (cmd.push) begin
      out_chan_r   <= cmd.push_chan;
      out_beacon_r <= cmd.push_loss ? BEACON_LOST : hit_r;
      out_last_r   <= cmd.push_last;
    end
  end

  assign status.req        = req_r;
  assign status.div_done   = (cnt_r == DIV_LAST);
  assign status.hit        = (hit_r != BEACON_LOST);
  assign status.lose_front = lose_f_r;
  assign status.lose_rear  = lose_rr_r;
  assign status.out_free   = out_free;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_beacon_r};
  assign out_tuser  = out_chan_r;
  assign out_tlast  = out_last_r;

endmodule

### hdl/bpc_checker.sv
// port-level checker of the beacon period classifier and its bind
`include "beacon_period_classifier_assert.svh"

module bpc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  // stalled result word stays offered
  `BPC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid)
  // one word in flight at a time
  `BPC_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)
  // beacon number in range
  `BPC_ASSERT_NOW(a_beacon_range, out_tvalid, out_tdata[2:0] <= 3'd4)
  // a loss word that is not the last one is always the front channel
  `BPC_ASSERT_NOW(a_loss_order, out_tvalid && (out_tdata[2:0] == 3'd0) && !out_tlast, !out_tuser)

endmodule

bind beacon_period_classifier bpc_checker u_bpc_checker (.*);

### tb/beacon_period_classifier_tb.sv
// self-checking testbench of the beacon period classifier: directed and random edge and tick words
module beacon_period_classifier_tb;
  import bpc_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [2:0] REG_SPARE0 = 3'd6;
  localparam logic [2:0] REG_SPARE1 = 3'd7;
  localparam int STALL_LIMIT = 3000;
  localparam int SETTLE = 64;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic       chan;
    logic [2:0] beacon;
    logic       fin;
  } sighting_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [31:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;   // capture_time, mode_allows, zero pad
  logic [1:0]  in_tuser = '0;   // req_type
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;       // beacon, zero pad
  logic        out_tuser;       // channel
  logic        out_tlast;

  beacon_period_classifier DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always #5 clk = ~clk;

  // predicted sightings still owed by the block
  sighting_t sightings_due[$];
  int fail_count = 0;
  int stall_cycles = 0;
  bit no_idle = 1'b0;
  int hold_off = 0;

  // classifier copy: settings and per-channel state
  logic [15:0] p_tpm;
  logic [15:0] p_nominal [4];
  logic [31:0] p_nob;
  logic [2:0]  p_seen [2];
  logic [31:0] p_time [2];
  logic [15:0] p_per [2];

  // stimulus-side view of settings and edge times
  logic [15:0] s_tpm;
  logic [15:0] s_nom [4];
  logic [31:0] s_nob;
  logic [31:0] chan_time [2];

  function automatic logic [15:0] period_in_ms(logic [31:0] elapsed);
    logic [31:0] q;
    if (p_tpm == 16'd0) return PERIOD_SAT;
    q = elapsed / {16'd0, p_tpm};
    return (q > 32'h0000_FFFF) ? PERIOD_SAT : q[15:0];
  endfunction

  task automatic classify_edge(input logic ch, input logic [31:0] t, input logic allow);
    logic [15:0] per;
    logic [15:0] nom;
    logic [2:0]  hit;
    per = period_in_ms(t - p_time[ch]);
    p_time[ch] = t;
    if (per != p_per[ch] && allow) begin
      p_per[ch] = per;
      hit = BEACON_LOST;
      for (int k = NUM_BEACONS - 1; k >= 0; k--) begin
        nom = p_nominal[k];
        if (p_seen[ch] != 3'(k + 1) && (per == nom || per == nom - 16'd1)) hit = 3'(k + 1);
      end
      if (hit != BEACON_LOST) begin
        p_seen[ch] = hit;
        sightings_due.push_back('{chan: ch, beacon: hit, fin: 1'b1});
      end
    end
  endtask

  task automatic check_loss(input logic [31:0] t);
    logic [31:0] since_front;
    logic [31:0] since_rear;
    logic lose_front;
    logic lose_rear;
    since_front = t - p_time[0];
    since_rear = t - p_time[1];
    lose_front = (p_seen[0] != BEACON_LOST) && (since_front > p_nob);
    lose_rear = (p_seen[1] != BEACON_LOST) && (since_rear > p_nob);
    if (lose_front) begin
      p_seen[0] = BEACON_LOST;
      sightings_due.push_back('{chan: 1'b0, beacon: BEACON_LOST, fin: !lose_rear});
    end
    if (lose_rear) begin
      p_seen[1] = BEACON_LOST;
      sightings_due.push_back('{chan: 1'b1, beacon: BEACON_LOST, fin: 1'b1});
    end
  endtask

  // result check, register tracking and prediction, all on the sampled edge
  always @(posedge clk) begin
    if (!rst_n) begin
      p_tpm = RST_TICKS_PER_MS;
      p_nominal[0] = RST_PERIOD_ONE;
      p_nominal[1] = RST_PERIOD_TWO;
      p_nominal[2] = RST_PERIOD_THREE;
      p_nominal[3] = RST_PERIOD_FOUR;
      p_nob = RST_NO_BEACON;
      for (int c = 0; c < 2; c++) begin
        p_seen[c] = BEACON_LOST;
        p_time[c] = '0;
        p_per[c] = '0;
      end
    end else begin
      if (out_tvalid && out_tready) begin
        if (sightings_due.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected word, got chan %0d beacon %0d last %0d", $time,
                   out_tuser, out_tdata, out_tlast);
        end else begin
          sighting_t want;
          want = sightings_due.pop_front();
          if (out_tuser !== want.chan || out_tdata !== {5'd0, want.beacon} ||
              out_tlast !== want.fin) begin
            fail_count++;
            $display("%0t: mismatch, expected chan %0d beacon %0d last %0d, got chan %0d beacon %0d last %0d",
                     $time, want.chan, want.beacon, want.fin, out_tuser, out_tdata, out_tlast);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_addr)
          REG_TICKS_PER_MS: p_tpm = cfg_wdata[15:0];
          REG_PERIOD_ONE:   p_nominal[0] = cfg_wdata[15:0];
          REG_PERIOD_TWO:   p_nominal[1] = cfg_wdata[15:0];
          REG_PERIOD_THREE: p_nominal[2] = cfg_wdata[15:0];
          REG_PERIOD_FOUR:  p_nominal[3] = cfg_wdata[15:0];
          REG_NO_BEACON:    p_nob = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        case (in_tuser)
          REQ_FRONT, REQ_REAR: classify_edge(in_tuser[0], in_tdata[31:0], in_tdata[32]);
          REQ_TICK:            check_loss(in_tdata[31:0]);
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin : receiver
    int stall;
    forever begin
      if (hold_off > 0) begin
        out_tready <= 1'b0;
        repeat (hold_off) @(posedge clk);
        hold_off = 0;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 7);
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  task automatic send_word(input logic [1:0] req, input logic [31:0] t, input logic allow);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= req;
    in_tdata <= {7'd0, allow, t};
    do @(posedge clk); while (!in_tready);
    if (req == REQ_FRONT || req == REQ_REAR) chan_time[req[0]] = t;
  endtask

  task automatic send_edge(input logic ch, input logic [31:0] delta, input logic allow);
    send_word(ch ? REQ_REAR : REQ_FRONT, chan_time[ch] + delta, allow);
  endtask

  task automatic drain(input int settle);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sightings_due.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic load_settings(input logic [15:0] tpm, input logic [15:0] p1,
                               input logic [15:0] p2, input logic [15:0] p3,
                               input logic [15:0] p4, input logic [31:0] nob);
    logic [31:0] vals [8];
    vals[REG_TICKS_PER_MS] = {16'($urandom), tpm};
    vals[REG_PERIOD_ONE] = {16'($urandom), p1};
    vals[REG_PERIOD_TWO] = {16'($urandom), p2};
    vals[REG_PERIOD_THREE] = {16'($urandom), p3};
    vals[REG_PERIOD_FOUR] = {16'($urandom), p4};
    vals[REG_NO_BEACON] = nob;
    vals[REG_SPARE0] = $urandom;
    vals[REG_SPARE1] = $urandom;
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_addr <= 3'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    s_tpm = tpm;
    s_nom[0] = p1;
    s_nom[1] = p2;
    s_nom[2] = p3;
    s_nom[3] = p4;
    s_nob = nob;
  endtask

  task automatic run_random(input int count);
    int made;
    int pick;
    logic ch;
    logic [15:0] nom;
    logic [31:0] t;
    made = 0;
    while (made < count) begin
      if (made % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      ch = 1'($urandom_range(0, 1));
      if (pick < 60) begin
        nom = s_nom[$urandom_range(0, 3)];
        if ($urandom_range(0, 1)) nom = nom - 16'd1;
        if (s_tpm == 16'd0) t = $urandom;
        else t = chan_time[ch] + 32'(nom) * 32'(s_tpm) + 32'($urandom_range(0, s_tpm - 1));
        send_word(ch ? REQ_REAR : REQ_FRONT, t, $urandom_range(0, 7) != 0);
      end else if (pick < 75) begin
        case ($urandom_range(0, 2))
          0: t = chan_time[ch] + s_nob + 32'($urandom_range(0, 4)) - 32'd2;
          1: t = chan_time[ch] + s_nob + 32'($urandom_range(1, 100000));
          default: t = chan_time[ch] + 32'($urandom_range(0, 200000));
        endcase
        send_word(REQ_TICK, t, 1'($urandom));
      end else if (pick < 95) begin
        send_word(ch ? REQ_REAR : REQ_FRONT, $urandom, 1'($urandom));
      end else begin
        send_word(REQ_UNUSED, $urandom, 1'($urandom));
      end
      if (pick < 95) made++;
    end
    no_idle = 1'b0;
  endtask

  task automatic test_edge_classes;
    send_word(REQ_FRONT, 32'd30000, 1'b1);
    send_word(REQ_REAR, 32'd28500, 1'b1);
    send_edge(1'b0, 32'd27000, 1'b1);
    send_edge(1'b0, 32'd27000, 1'b1);
    send_edge(1'b0, 32'd24000, 1'b0);
    send_edge(1'b0, 32'd24000, 1'b1);
    send_edge(1'b0, 32'd21000, 1'b1);
    send_edge(1'b0, 32'd19500, 1'b1);
    send_edge(1'b0, 32'd1000, 1'b1);
    send_word(REQ_UNUSED, 32'hFFFF_FFFF, 1'b1);
  endtask

  task automatic test_loss_ticks;
    logic [31:0] newest;
    send_word(REQ_TICK, chan_time[0] + s_nob, 1'b0);
    send_word(REQ_TICK, chan_time[0] + s_nob + 32'd1, 1'b1);
    send_edge(1'b0, 32'd30000, 1'b1);
    send_edge(1'b1, 32'd27000, 1'b1);
    newest = (chan_time[0] > chan_time[1]) ? chan_time[0] : chan_time[1];
    send_word(REQ_TICK, newest + s_nob + 32'd1, 1'b0);
    send_word(REQ_TICK, newest + s_nob + 32'd2, 1'b0);
  endtask

  task automatic test_special_settings;
    logic [31:0] newest;
    drain(SETTLE);
    // zero divisor saturates, a zero nominal period matches the saturated value
    load_settings(16'd0, 16'd20, 16'd18, 16'd16, 16'd0, 32'd1);
    send_edge(1'b0, 32'd100, 1'b1);
    send_edge(1'b1, 32'd7, 1'b1);
    newest = (chan_time[0] > chan_time[1]) ? chan_time[0] : chan_time[1];
    send_word(REQ_TICK, newest + 32'd2, 1'b0);
    drain(SETTLE);
    // timestamp wrap and quotient saturation
    load_settings(16'd1, 16'hFFFF, 16'd21, 16'd1, 16'd2, 32'hFFFF_FFFF);
    send_word(REQ_FRONT, 32'hFFFF_FFF0, 1'b1);
    send_word(REQ_FRONT, 32'd5, 1'b1);
    send_edge(1'b0, 32'd65540, 1'b1);
    send_edge(1'b0, 32'd0, 1'b1);
    send_word(REQ_TICK, chan_time[0] - 32'd1, 1'b0);
  endtask

  task automatic test_random_defaults;
    drain(SETTLE);
    load_settings(RST_TICKS_PER_MS, RST_PERIOD_ONE, RST_PERIOD_TWO, RST_PERIOD_THREE,
                  RST_PERIOD_FOUR, RST_NO_BEACON);
    run_random(200);
    // sender waits for every owed word before going on
    drain(0);
    run_random(200);
  endtask

  task automatic test_random_narrow;
    drain(SETTLE);
    load_settings(16'($urandom_range(1, 16)), 16'($urandom_range(1, 64)),
                  16'($urandom_range(1, 64)), 16'($urandom_range(1, 64)),
                  16'($urandom_range(1, 64)), 32'($urandom_range(1, 2000)));
    run_random(450);
  endtask

  task automatic test_random_extremes;
    drain(SETTLE);
    load_settings(16'hFFFF, 16'hFFFF, 16'($urandom_range(3, 65534)), 16'd2, 16'd1,
                  32'hFFFF_FFFF);
    run_random(200);
    drain(SETTLE);
    load_settings(16'd1, 16'($urandom_range(1, 30)), 16'($urandom_range(1, 30)),
                  16'($urandom_range(1, 30)), 16'($urandom_range(1, 30)), 32'd1);
    run_random(200);
  endtask

  task automatic test_receiver_backpressure;
    drain(SETTLE);
    load_settings(16'($urandom_range(100, 3000)), 16'($urandom_range(10, 60)),
                  16'($urandom_range(10, 60)), 16'($urandom_range(10, 60)),
                  16'($urandom_range(10, 60)), 32'($urandom_range(10000, 200000)));
    hold_off = HOLD_CYCLES;
    run_random(300);
  endtask

  initial begin
    s_tpm = RST_TICKS_PER_MS;
    s_nom[0] = RST_PERIOD_ONE;
    s_nom[1] = RST_PERIOD_TWO;
    s_nom[2] = RST_PERIOD_THREE;
    s_nom[3] = RST_PERIOD_FOUR;
    s_nob = RST_NO_BEACON;
    chan_time[0] = '0;
    chan_time[1] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_edge_classes();
    test_loss_ticks();
    test_special_settings();
    test_random_defaults();
    test_random_narrow();
    test_random_extremes();
    test_receiver_backpressure();
    drain(SETTLE);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
